// ===== src/twcml_pkg.sv =====
package twcml_pkg;

    // both dividends are 33 bits wide: the window end carries out of 32 bits
    localparam int DIV_W     = 33;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        CMD_QUERY        = 2'd0,
        CMD_MARK_BAD     = 2'd1,
        CMD_ZAP_CHAN     = 2'd2,
        CMD_ZAP_INTERVAL = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_INTERVAL_LENGTH = 2'd0,
        CFG_NUM_INTERVALS   = 2'd1,
        CFG_NUM_CHANNELS    = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RMW_RD,
        S_RMW_WR,
        S_DIV_START,
        S_DIV,
        S_CLAMP,
        S_RD_LO,
        S_RD_HI,
        S_MERGE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic set_glob;
        logic clr_we;
        logic rmw_rd;
        logic rmw_wr;
        logic div_start;
        logic clamp;
        logic rd_lo;
        logic rd_hi;
        logic merge;
        logic emit;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic load_ok;
        logic div_busy;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/twcml_ctrl.sv =====
module twcml_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  twcml_pkg::t_dp_sts  i_sts,
    output twcml_pkg::t_dp_ctl  o_ctl
);
    import twcml_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_QUERY: n_state = S_DIV_START;
                    CMD_MARK_BAD, CMD_ZAP_INTERVAL: begin
                        n_state = i_sts.load_ok ? S_RMW_RD : S_EMIT;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_RMW_RD:    n_state = S_RMW_WR;
            S_RMW_WR:    n_state = S_EMIT;
            S_DIV_START: n_state = S_DIV;
            S_DIV: begin
                if (!i_sts.div_busy) n_state = S_CLAMP;
            end
            S_CLAMP: n_state = S_RD_LO;
            S_RD_LO: n_state = S_RD_HI;
            S_RD_HI: n_state = S_MERGE;
            S_MERGE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_ctl.clr_we = 1'b1;
            S_IDLE: begin
                o_s_ready    = 1'b1;
                o_ctl.accept = i_s_valid;
            end
            S_DECODE:    o_ctl.set_glob  = (i_sts.cmd == CMD_ZAP_CHAN);
            S_RMW_RD:    o_ctl.rmw_rd    = 1'b1;
            S_RMW_WR:    o_ctl.rmw_wr    = 1'b1;
            S_DIV_START: o_ctl.div_start = 1'b1;
            S_DIV:       ;
            S_CLAMP:     o_ctl.clamp     = 1'b1;
            S_RD_LO:     o_ctl.rd_lo     = 1'b1;
            S_RD_HI:     o_ctl.rd_hi     = 1'b1;
            S_MERGE:     o_ctl.merge     = 1'b1;
            S_EMIT:      o_ctl.emit      = i_sts.out_free;
            default:     ;
        endcase
    end

endmodule

// ===== src/twcml_div.sv =====
module twcml_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [twcml_pkg::DIV_W-1:0]   i_num0,
    input  logic [twcml_pkg::DIV_W-1:0]   i_num1,
    input  logic [31:0]                   i_den,
    output logic                          o_busy,
    output logic [twcml_pkg::DIV_W-1:0]   o_quo0,
    output logic [twcml_pkg::DIV_W-1:0]   o_quo1
);
    import twcml_pkg::*;

    // two restoring dividers in lockstep, one quotient bit per cycle each
    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [31:0]          r_den;
    logic [DIV_W-1:0]     r_q   [2];
    logic [31:0]          r_rem [2];
    logic [32:0]          shl   [2];
    logic [32:0]          diff  [2];
    logic                 ge    [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            shl[k]  = {r_rem[k], r_q[k][DIV_W-1]};
            diff[k] = shl[k] - {1'b0, r_den};
            ge[k]   = (shl[k] >= {1'b0, r_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den    <= i_den;
            r_q[0]   <= i_num0;
            r_q[1]   <= i_num1;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end else if (r_busy) begin
            for (int k = 0; k < 2; k++) begin
                r_rem[k] <= ge[k] ? diff[k][31:0] : shl[k][31:0];
                r_q[k]   <= {r_q[k][DIV_W-2:0], ge[k]};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo0 = r_q[0];
    assign o_quo1 = r_q[1];

endmodule

// ===== src/twcml_dp.sv =====
module twcml_dp #(
    parameter int MAX_INTERVALS = 1024,
    parameter int MAX_CHANNELS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic [79:0]         i_s_data,
    input  logic [1:0]          i_s_user,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output logic [95:0]         o_m_data,
    output logic [0:0]          o_m_user,
    input  twcml_pkg::t_dp_ctl  i_ctl,
    output twcml_pkg::t_dp_sts  o_sts
);
    import twcml_pkg::*;

    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int NW = $clog2(MAX_INTERVALS + 1);

    // configuration
    logic [31:0] r_cfg_len;
    logic [10:0] r_cfg_nint;
    logic [6:0]  r_cfg_nch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len  <= 32'd1;
            r_cfg_nint <= 11'd1024;
            r_cfg_nch  <= 7'd64;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INTERVAL_LENGTH: r_cfg_len  <= i_cfg_data;
                CFG_NUM_INTERVALS:   r_cfg_nint <= i_cfg_data[10:0];
                CFG_NUM_CHANNELS:    r_cfg_nch  <= i_cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    logic [31:0]   den;
    logic [31:0]   nint32;
    logic [NW-1:0] nint_eff;
    logic [NW-1:0] nint_m1;
    logic [6:0]    nch_eff;
    logic [63:0]   chan_mask;

    always_comb begin
        den = (r_cfg_len == '0) ? 32'd1 : r_cfg_len;
        if (r_cfg_nint == '0) begin
            nint32 = 32'd1;
        end else if (32'(r_cfg_nint) > 32'(MAX_INTERVALS)) begin
            nint32 = 32'(MAX_INTERVALS);
        end else begin
            nint32 = 32'(r_cfg_nint);
        end
        nint_eff = nint32[NW-1:0];
        nint_m1  = nint_eff - 1'b1;
        if (r_cfg_nch == '0) begin
            nch_eff = 7'd1;
        end else if (32'(r_cfg_nch) > 32'(MAX_CHANNELS)) begin
            nch_eff = 7'(MAX_CHANNELS);
        end else begin
            nch_eff = r_cfg_nch;
        end
        chan_mask = nch_eff[6] ? '1 : ((64'd1 << nch_eff[5:0]) - 64'd1);
    end

    // latched input transfer
    t_cmd        r_cmd;
    logic [31:0] r_start;
    logic [31:0] r_wlen;
    logic [9:0]  r_isel;
    logic [5:0]  r_csel;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd   <= t_cmd'(i_s_user);
            r_start <= i_s_data[31:0];
            r_wlen  <= i_s_data[63:32];
            r_isel  <= i_s_data[73:64];
            r_csel  <= i_s_data[79:74];
        end
    end

    logic [31:0]   isel_ext;
    logic          isel_ok;
    logic          csel_ok;
    logic [IW-1:0] isel_addr;

    always_comb begin
        isel_ext  = 32'(r_isel);
        isel_ok   = (isel_ext < 32'(MAX_INTERVALS));
        csel_ok   = (32'(r_csel) < 32'(MAX_CHANNELS));
        isel_addr = isel_ext[IW-1:0];
    end

    logic [63:0] r_glob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glob <= '0;
        end else if (i_ctl.set_glob && csel_ok) begin
            r_glob <= r_glob | (64'd1 << r_csel);
        end
    end

    // interval store: bit 64 is the zap flag, bits 63:0 the bad channels
    logic [64:0]   r_mem [MAX_INTERVALS];
    logic [64:0]   r_rd_data;
    logic [IW-1:0] r_clr_addr;
    logic [IW-1:0] r_lo;
    logic [IW-1:0] r_hi;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [64:0]   wr_data;
    logic          wr_en;

    always_comb begin
        if (i_ctl.rd_lo) begin
            rd_addr = r_lo;
        end else if (i_ctl.rd_hi) begin
            rd_addr = r_hi;
        end else begin
            rd_addr = isel_addr;
        end
        wr_en   = i_ctl.clr_we | i_ctl.rmw_wr;
        wr_addr = i_ctl.clr_we ? r_clr_addr : isel_addr;
        if (i_ctl.clr_we) begin
            wr_data = '0;
        end else if (r_cmd == CMD_ZAP_INTERVAL) begin
            wr_data = r_rd_data | {1'b1, 64'd0};
        end else begin
            wr_data = r_rd_data | (65'd1 << r_csel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clr_we) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // interval division
    logic             div_busy;
    logic [DIV_W-1:0] quo_lo;
    logic [DIV_W-1:0] quo_hi;

    twcml_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num0  (DIV_W'(r_start)),
        .i_num1  (DIV_W'(r_start) + DIV_W'(r_wlen)),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quo0  (quo_lo),
        .o_quo1  (quo_hi)
    );

    logic [IW-1:0] lo_clamp;
    logic [IW-1:0] hi_clamp;

    always_comb begin
        lo_clamp = (quo_lo >= DIV_W'(nint_eff)) ? nint_m1[IW-1:0] : quo_lo[IW-1:0];
        hi_clamp = (quo_hi >= DIV_W'(nint_eff)) ? lo_clamp : quo_hi[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clamp) begin
            r_lo <= lo_clamp;
            r_hi <= hi_clamp;
        end
    end

    logic [64:0] r_word_lo;
    logic [63:0] r_bits;
    logic        r_zap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_hi) r_word_lo <= r_rd_data;
        if (i_ctl.merge) begin
            r_zap  <= r_word_lo[64] | r_rd_data[64];
            r_bits <= (r_glob | r_word_lo[63:0] | r_rd_data[63:0]) & chan_mask;
        end
    end

    // adder tree keeps the count shallow
    function automatic logic [6:0] popcount(input logic [63:0] v);
        logic [1:0] s2  [32];
        logic [2:0] s4  [16];
        logic [3:0] s8  [8];
        logic [4:0] s16 [4];
        logic [5:0] s32 [2];
        for (int k = 0; k < 32; k++) s2[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
        for (int k = 0; k < 16; k++) s4[k] = {1'b0, s2[2*k]} + {1'b0, s2[2*k+1]};
        for (int k = 0; k < 8; k++) s8[k] = {1'b0, s4[2*k]} + {1'b0, s4[2*k+1]};
        for (int k = 0; k < 4; k++) s16[k] = {1'b0, s8[2*k]} + {1'b0, s8[2*k+1]};
        for (int k = 0; k < 2; k++) s32[k] = {1'b0, s16[2*k]} + {1'b0, s16[2*k+1]};
        return {1'b0, s32[0]} + {1'b0, s32[1]};
    endfunction

    // result register
    logic        r_m_valid;
    logic [95:0] r_m_data;
    logic        r_m_user;
    logic [31:0] lo_ext;
    logic [31:0] hi_ext;
    logic [63:0] res_bits;
    logic [6:0]  res_count;

    always_comb begin
        lo_ext = 32'(r_lo);
        hi_ext = 32'(r_hi);
        if (r_zap) begin
            res_bits  = chan_mask;
            res_count = nch_eff;
        end else begin
            res_bits  = r_bits;
            res_count = popcount(r_bits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            if (r_cmd == CMD_QUERY) begin
                r_m_data <= {5'd0, hi_ext[9:0], lo_ext[9:0], res_count, res_bits};
                r_m_user <= r_zap;
            end else begin
                r_m_data <= '0;
                r_m_user <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_user  = r_m_user;

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.load_ok  = (r_cmd == CMD_MARK_BAD) ? (isel_ok & csel_ok) : isel_ok;
        o_sts.div_busy = div_busy;
        o_sts.clr_last = (32'(r_clr_addr) == 32'(MAX_INTERVALS - 1));
        o_sts.out_free = !r_m_valid || i_m_ready;
    end

endmodule

// ===== src/time_window_channel_mask_lookup_top.sv =====
// a query's result passes through a shift-subtract division of both window ends,
// then clamp, two store reads and merge before it is registered at the output
// a load command gives an all-zero result
// one item at a time: a new transfer is taken only once the last result is emitted
// reset: synchronous; afterwards the interval store is cleared one entry a cycle,
// with s_axis_tready low until every entry is cleared
module time_window_channel_mask_lookup_top #(
    parameter int MAX_INTERVALS = 1024,
    parameter int MAX_CHANNELS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_time, window_length, interval_select, channel_select
    input  logic [79:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // channel_bitmap, masked_count, first_interval, last_interval, zero fill
    output logic [95:0] m_axis_tdata,
    // all_masked
    output logic [0:0]  m_axis_tuser
);
    import twcml_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    twcml_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    twcml_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_data   (s_axis_tdata),
        .i_s_user   (s_axis_tuser),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_data   (m_axis_tdata),
        .o_m_user   (m_axis_tuser),
        .i_ctl      (ctl),
        .o_sts      (sts)
    );

endmodule
